/* hdl/mdt_pkg.sv */
// Package for the multi-slot deadline timer: command and result codes,
// the queue entry type and shared constants. Depends on nothing.
package mdt_pkg;

	localparam int MDT_NUM_SLOTS = 16;
	localparam int MAX_RES = 16;
	localparam int TIME_W = 32;

	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_DESTROY = 2'd1,
		CMD_TICK    = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_CREATED = 2'd0,
		KIND_REFUSED = 2'd1,
		KIND_DESTROY = 2'd2,
		KIND_EXPIRED = 2'd3
	} kind_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] duration;
		logic [3:0]  slot;
	} cmd_item_t;

endpackage

/* hdl/mdt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module mdt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* hdl/mdt_front.sv */
// Front end of the deadline timer: accepts items, drops the unused command
// code and holds the rest in a two-entry queue. Depends on mdt_pkg.
module mdt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [15:0]       duration,
	input  logic [3:0]        slot,
	output logic              q_valid,
	output mdt_pkg::cmd_item_t q_item,
	input  logic              q_pop
);
	import mdt_pkg::*;

	cmd_item_t mem_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] cnt_q;
	logic      push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall && (cmd_t'(command) != CMD_NOP);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{cmd: cmd_t'(command), duration: duration, slot: slot};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, q_pop});
		end
	end
endmodule

/* hdl/mdt_back.sv */
// Back end of the deadline timer: slot table, time counter, expiry scan and
// the output register. Depends on mdt_pkg and mdt_ram.
module mdt_back #(
	parameter int NUM_SLOTS = mdt_pkg::MDT_NUM_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  mdt_pkg::cmd_item_t q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [3:0]         slot_number,
	output logic               was_active,
	output logic               last
);
	import mdt_pkg::*;

	localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SCAN    = 5'b00010,
		ST_LAST    = 5'b00100,
		ST_RESOLVE = 5'b01000,
		ST_FLUSH   = 5'b10000
	} state_t;

	state_t               state_q;
	logic [NUM_SLOTS-1:0] in_use_q;
	logic [TIME_W-1:0]    time_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 cmp_v_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic                 found_q;
	logic [TIME_W-1:0]    best_q;
	logic [IDX_W-1:0]     pick_q;
	logic                 pend_v_q;
	logic [IDX_W-1:0]     pend_q;
	logic [4:0]           n_q;
	logic                 out_v_q;
	kind_t                kind_q;
	logic [3:0]           slot_q;
	logic                 act_q;
	logic                 last_q;

	logic                 out_free;
	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic [IDX_W-1:0]     dst_idx;
	logic                 dst_act;
	logic                 ram_we;
	logic [TIME_W-1:0]    ram_wdata;
	logic [TIME_W-1:0]    ram_rdata;
	logic [TIME_W-1:0]    age;
	logic                 better;

	assign out_free = !out_v_q || !out_stall;
	assign q_pop = (state_q == ST_IDLE) && q_valid && out_free;

	// Lowest free slot, found by a priority encoder over the in-use bits.
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign dst_idx = IDX_W'(q_item.slot);
	assign dst_act = ({28'd0, q_item.slot} < 32'(NUM_SLOTS)) && in_use_q[dst_idx];

	assign ram_we = q_pop && (q_item.cmd == CMD_CREATE) && free_found;
	assign ram_wdata = time_q + {16'd0, q_item.duration};

	mdt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_deadline (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (free_idx),
		.wr_data (ram_wdata),
		.rd_addr (idx_q),
		.rd_data (ram_rdata)
	);

	// A slot is due when its age is non-negative; the oldest wins and strict
	// comparison keeps the lowest slot on ties.
	assign age = time_q - ram_rdata;
	assign better = cmp_v_s1 && in_use_q[cmp_idx_s1] && !age[TIME_W-1]
		&& (!found_q || age > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_use_q <= '0;
			time_q <= '0;
			idx_q <= '0;
			cmp_v_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			pick_q <= '0;
			pend_v_q <= 1'b0;
			pend_q <= '0;
			n_q <= '0;
			out_v_q <= 1'b0;
			kind_q <= KIND_CREATED;
			slot_q <= '0;
			act_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			cmp_v_s1 <= 1'b0;
			cmp_idx_s1 <= idx_q;
			if (better) begin
				found_q <= 1'b1;
				best_q <= age;
				pick_q <= cmp_idx_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_item.cmd)
							CMD_CREATE: begin
								out_v_q <= 1'b1;
								act_q <= 1'b0;
								last_q <= 1'b1;
								if (free_found) begin
									in_use_q[free_idx] <= 1'b1;
									kind_q <= KIND_CREATED;
									slot_q <= 4'(free_idx);
								end else begin
									kind_q <= KIND_REFUSED;
									slot_q <= '0;
								end
							end
							CMD_DESTROY: begin
								if (dst_act) begin
									in_use_q[dst_idx] <= 1'b0;
								end
								out_v_q <= 1'b1;
								kind_q <= KIND_DESTROY;
								slot_q <= q_item.slot;
								act_q <= dst_act;
								last_q <= 1'b1;
							end
							CMD_TICK: begin
								time_q <= time_q + 1'b1;
								pend_v_q <= 1'b0;
								n_q <= '0;
								idx_q <= '0;
								found_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					cmp_v_s1 <= 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LAST: begin
					state_q <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q <= 1'b1;
							kind_q <= KIND_EXPIRED;
							slot_q <= 4'(pend_q);
							act_q <= 1'b0;
							last_q <= !found_q;
						end
						if (found_q) begin
							in_use_q[pick_q] <= 1'b0;
							pend_q <= pick_q;
							pend_v_q <= 1'b1;
							n_q <= n_q + 1'b1;
							idx_q <= '0;
							found_q <= 1'b0;
							if (5'(n_q + 1'b1) == 5'(MAX_RES)) begin
								state_q <= ST_FLUSH;
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							pend_v_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						kind_q <= KIND_EXPIRED;
						slot_q <= 4'(pend_q);
						act_q <= 1'b0;
						last_q <= 1'b1;
						pend_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign kind = kind_q;
	assign slot_number = slot_q;
	assign was_active = act_q;
	assign last = last_q;
endmodule

/* hdl/multi_slot_deadline_timer.sv */
// Top level of the multi-slot deadline timer: front-end queue and back end.
// Depends on mdt_pkg, mdt_front, mdt_back and mdt_ram.

// Create and destroy commands are handled in the back end and give one
// result each. A tick advances the time counter and then scans the slot
// table through the single read port of the deadline memory, once per expiry
// and, below the limit of 16 expiries, once more to find that none is left.
// A stalled output holds up both results and scans. A two-entry queue lets
// new items be accepted while a tick is still being worked off. Command
// code 3 is dropped.
module multi_slot_deadline_timer #(
	parameter int NUM_SLOTS = mdt_pkg::MDT_NUM_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] duration,
	input  logic [3:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  slot_number,
	output logic        was_active,
	output logic        last
);
	import mdt_pkg::*;

	logic      q_valid;
	cmd_item_t q_item;
	logic      q_pop;

	mdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.duration (duration),
		.slot     (slot),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	mdt_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.slot_number (slot_number),
		.was_active  (was_active),
		.last        (last)
	);
endmodule

/* verif/multi_slot_deadline_timer_test.sv */
// Self-checking testbench for multi_slot_deadline_timer: drives all four commands
// under random idling and output stalls, checks every result. Depends on mdt_pkg.
module multi_slot_deadline_timer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mdt_pkg::*;

	localparam int NSLOT = MDT_NUM_SLOTS;
	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] slot_number;
		logic       was_active;
		logic       last;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = CMD_NOP;
	logic [15:0] duration = '0;
	logic [3:0] slot = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic [3:0] slot_number;
	logic was_active;
	logic last;

	multi_slot_deadline_timer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .duration(duration), .slot(slot),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .slot_number(slot_number), .was_active(was_active), .last(last)
	);

	always #2 clk = ~clk;

	// Predictor state.
	logic        busy_slot [NSLOT];
	logic [31:0] due_time [NSLOT];
	logic [31:0] now_ticks;

	cmd_item_t     pending_items [$];
	timer_result_t expected_results [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic timer_result_t mk(kind_t k, logic [3:0] s, logic a, logic l);
		timer_result_t r;
		r.kind = k; r.slot_number = s; r.was_active = a; r.last = l;
		return r;
	endfunction

	task automatic predict_timer(input cmd_item_t it);
		int i, pick, n;
		logic [31:0] age, best_age;
		case (it.cmd)
			CMD_CREATE: begin
				pick = -1;
				for (i = NSLOT - 1; i >= 0; i--)
					if (!busy_slot[i]) pick = i;
				if (pick < 0) begin
					expected_results.push_back(mk(KIND_REFUSED, 4'd0, 1'b0, 1'b1));
				end else begin
					busy_slot[pick] = 1'b1;
					due_time[pick] = now_ticks + 32'(it.duration);
					expected_results.push_back(mk(KIND_CREATED, 4'(pick), 1'b0, 1'b1));
				end
			end
			CMD_DESTROY: begin
				if (busy_slot[it.slot]) begin
					busy_slot[it.slot] = 1'b0;
					expected_results.push_back(mk(KIND_DESTROY, it.slot, 1'b1, 1'b1));
				end else begin
					expected_results.push_back(mk(KIND_DESTROY, it.slot, 1'b0, 1'b1));
				end
			end
			CMD_TICK: begin
				now_ticks = now_ticks + 1;
				n = 0;
				while (n < MAX_RES) begin
					pick = -1;
					best_age = '0;
					for (i = 0; i < NSLOT; i++) begin
						age = now_ticks - due_time[i];
						if (busy_slot[i] && !age[31] && (pick < 0 || age > best_age)) begin
							pick = i;
							best_age = age;
						end
					end
					if (pick < 0) break;
					busy_slot[pick] = 1'b0;
					expected_results.push_back(mk(KIND_EXPIRED, 4'(pick), 1'b0, 1'b0));
					n++;
				end
				if (n > 0) expected_results[$].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_valid) predict_timer(cmd_item_t'({command, duration, slot}));
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					{command, duration, slot} <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected result kind %0d slot %0d", kind, slot_number));
				end else begin
					timer_result_t e;
					e = expected_results.pop_front();
					if (kind !== e.kind || slot_number !== e.slot_number ||
							was_active !== e.was_active || last !== e.last)
						report($sformatf("got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
							kind, slot_number, was_active, last,
							e.kind, e.slot_number, e.was_active, e.last));
				end
			end
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic cmd_item_t item(cmd_t c, logic [15:0] d, logic [3:0] s);
		cmd_item_t it;
		it.cmd = c; it.duration = d; it.slot = s;
		return it;
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			pending_items.push_back(item(CMD_CREATE,
				($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12)),
				4'($urandom)));
		else if (r < 55)
			pending_items.push_back(item(CMD_DESTROY, 16'($urandom), 4'($urandom)));
		else if (r < 97)
			pending_items.push_back(item(CMD_TICK, 16'($urandom), 4'($urandom)));
		else
			pending_items.push_back(item(CMD_NOP, 16'($urandom), 4'($urandom)));
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	initial begin
		int i, ph;
		for (i = 0; i < NSLOT; i++) begin
			busy_slot[i] = 1'b0;
			due_time[i] = '0;
		end
		now_ticks = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero duration, equal deadlines, table full, destroys, command 3.
		pending_items.push_back(item(CMD_TICK, 16'h0000, 4'h0));
		pending_items.push_back(item(CMD_CREATE, 16'h0000, 4'hF));
		pending_items.push_back(item(CMD_TICK, 16'hFFFF, 4'h0));
		for (i = 0; i < NSLOT; i++) pending_items.push_back(item(CMD_CREATE, 16'd2, 4'h0));
		pending_items.push_back(item(CMD_CREATE, 16'hFFFF, 4'hF));
		pending_items.push_back(item(CMD_DESTROY, 16'h0, 4'hF));
		pending_items.push_back(item(CMD_DESTROY, 16'h0, 4'hF));
		pending_items.push_back(item(CMD_CREATE, 16'hFFFF, 4'h0));
		pending_items.push_back(item(CMD_NOP, 16'hFFFF, 4'hF));
		pending_items.push_back(item(CMD_TICK, 16'h0, 4'h0));
		pending_items.push_back(item(CMD_TICK, 16'h0, 4'h0));
		pending_items.push_back(item(CMD_DESTROY, 16'h0, 4'h0));
		drain();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 59) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 25 : 59) : 0;
			for (i = 0; i < 125; i++) random_item();
			drain();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

/* sim.f */
hdl/mdt_pkg.sv
hdl/mdt_ram.sv
hdl/mdt_front.sv
hdl/mdt_back.sv
hdl/multi_slot_deadline_timer.sv
verif/multi_slot_deadline_timer_test.sv
